/* design/dtpm_pkg.sv */
package dtpm_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned DIVIDEND_W  = 23;

  localparam logic [6:0]  FULL_PCT       = 7'd100;
  localparam logic [15:0] RESET_DEBOUNCE = 16'd1000;
  localparam logic [15:0] RESET_PUSH     = 16'd500;
  localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;

  typedef enum logic [1:0] {
    MOVE_NONE = 2'd0,
    MOVE_UP   = 2'd1,
    MOVE_DOWN = 2'd2
  } move_t;

  typedef enum logic [1:0] {
    CFG_TRAVEL_TIME = 2'd0,
    CFG_MIN_STEP    = 2'd1,
    CFG_DEBOUNCE    = 2'd2,
    CFG_PUSH        = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic opening_active;
    logic closing_active;
    logic closed_contact;
    logic enable_level;
    logic push_request;
  } in_t;

  typedef struct packed {
    logic       command_level;
    logic       report_due;
    logic [1:0] move_state;
    logic [6:0] position_pct;
    logic       closed_flag;
    logic       enabled_flag;
  } out_t;

  typedef struct packed {
    logic [15:0] travel_time_ms;
    logic [6:0]  min_report_step;
    logic [15:0] debounce_ms;
    logic [15:0] push_ms;
  } cfg_t;

  typedef struct packed {
    move_t req_move;
    logic  closed_contact;
    logic  enable_level;
    logic  push_request;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_link_t;

endpackage

/* design/door_travel_position_monitor.sv */
// Garage door travel and position monitor, one input beat per millisecond tick.
// Input channel (in_valid/in_ready/in_data): direction inputs, closed contact,
// enable level and push request for one tick. Output channel
// (out_valid/out_ready/out_data): exactly one result beat per input beat, in order,
// with command level, status flag, move, position in percent and latched flags.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle with no
// wait; write only while no tick is in flight.
// A tick that needs a position estimate passes through the 23-step radix-2
// divider that computes elapsed*100/travel_time before its result is issued;
// other ticks go straight to the result register. Ticks are processed one at a
// time, so the next tick is not taken until the last result has been issued.
// A two-beat input queue keeps in_ready high while a tick is being worked on or
// a result waits; when out_ready stays low the result register holds and the
// queue fills, then in_ready drops.
// Reset (rst, synchronous): clears all timers, the move, position and flags,
// empties the queue, and loads debounce 1000 and push width 500 ticks.
module door_travel_position_monitor #(
  parameter int unsigned QUEUE_DEPTH = dtpm_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  dtpm_pkg::cfg_reg_t cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  dtpm_pkg::in_t      in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dtpm_pkg::out_t     out_data
);
  import dtpm_pkg::*;

  cfg_t    cfg;
  q_link_t head;
  logic    pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.travel_time_ms  <= '0;
      cfg.min_report_step <= '0;
      cfg.debounce_ms     <= RESET_DEBOUNCE;
      cfg.push_ms         <= RESET_PUSH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRAVEL_TIME: cfg.travel_time_ms  <= cfg_data;
        CFG_MIN_STEP:    cfg.min_report_step <= cfg_data[6:0];
        CFG_DEBOUNCE:    cfg.debounce_ms     <= cfg_data;
        CFG_PUSH:        cfg.push_ms         <= cfg_data;
        default:         cfg.push_ms         <= cfg.push_ms;
      endcase
    end
  end

  dtpm_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .head     (head),
    .pop      (pop)
  );

  dtpm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.position_pct <= FULL_PCT))
    else $error("position above full scale");

  a_no_send_disabled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.enabled_flag) |-> !out_data.report_due)
    else $error("status report while disabled");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("queue popped while empty");
`endif

endmodule

/* design/dtpm_front.sv */
module dtpm_front #(
  parameter int unsigned DEPTH = dtpm_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dtpm_pkg::in_t   in_data,
  output dtpm_pkg::q_link_t head,
  input  logic            pop
);
  import dtpm_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  q_entry_t        queue [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  q_entry_t        entry_in;
  logic            push;
  logic            take;

  always_comb begin
    entry_in                = '0;
    entry_in.closed_contact = in_data.closed_contact;
    entry_in.enable_level   = in_data.enable_level;
    entry_in.push_request   = in_data.push_request;
    if (in_data.opening_active) begin
      entry_in.req_move = MOVE_UP;
    end else if (in_data.closing_active) begin
      entry_in.req_move = MOVE_DOWN;
    end else begin
      entry_in.req_move = MOVE_NONE;
    end
  end

  assign in_ready   = (count != CW'(DEPTH));
  assign push       = in_valid && in_ready;
  assign take       = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.entry = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (take) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, take})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/dtpm_div.sv */
module dtpm_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [dtpm_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [15:0]                      divisor,
  output logic                             done,
  output logic [dtpm_pkg::DIVIDEND_W-1:0]  quotient
);
  import dtpm_pkg::*;

  localparam int unsigned NW = $clog2(DIVIDEND_W);

  logic [15:0]           rem;
  logic [15:0]           dvs;
  logic [DIVIDEND_W-1:0] quo;
  logic [NW-1:0]         cnt;
  logic                  busy;
  logic [16:0]           trial;
  logic                  fits;

  assign trial    = {rem, quo[DIVIDEND_W-1]};
  assign fits     = (trial >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? 16'(trial - {1'b0, dvs}) : trial[15:0];
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= NW'(DIVIDEND_W - 1);
      end else if (busy) begin
        cnt <= cnt - NW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/dtpm_back.sv */
module dtpm_back (
  input  logic              clk,
  input  logic              rst,
  input  dtpm_pkg::cfg_t    cfg,
  input  dtpm_pkg::q_link_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output dtpm_pkg::out_t    out_data
);
  import dtpm_pkg::*;

  back_state_t state;
  back_state_t state_next;

  move_t       move_reg;
  logic [15:0] elapsed_ms;
  logic [15:0] debounce_left;
  logic [15:0] pulse_left;
  logic [6:0]  position_reg;
  logic [6:0]  reported_position;
  logic        closed_reg;
  logic        enabled_reg;
  logic        cmd_pend;
  logic        send_pend;

  move_t       move_next;
  logic [15:0] elapsed_next;
  logic [15:0] debounce_next;
  logic [15:0] pulse_next;
  logic        closed_next;
  logic        cmd_next;
  logic        send_next;
  logic        need_pos;

  logic [15:0] pulse_load;
  logic        hold;
  move_t       cur;

  logic                  div_start;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_q;
  logic [DIVIDEND_W-1:0] dividend;

  logic [6:0]  pos_clamp;
  logic [6:0]  pos;
  logic [6:0]  diff;
  logic        pos_report;
  logic        pos_take;
  logic        emit;

  q_entry_t    e;

  assign e = head.entry;

  always_comb begin
    pulse_load    = e.push_request ? cfg.push_ms : pulse_left;
    cmd_next      = (pulse_load != '0);
    pulse_next    = cmd_next ? pulse_load - 16'd1 : pulse_load;
    hold          = (debounce_left != '0);
    cur           = hold ? move_reg : e.req_move;
    move_next     = move_reg;
    elapsed_next  = (elapsed_ms != ELAPSED_MAX) ? elapsed_ms + 16'd1 : elapsed_ms;
    debounce_next = hold ? debounce_left - 16'd1 : debounce_left;
    closed_next   = closed_reg;
    send_next     = 1'b0;
    need_pos      = 1'b0;
    if (e.enable_level) begin
      if (!hold && e.req_move == MOVE_NONE && move_reg != MOVE_NONE) begin
        debounce_next = cfg.debounce_ms;
      end
      if (cur != move_reg) begin
        move_next = cur;
        send_next = 1'b1;
        if (cur != MOVE_NONE) begin
          elapsed_next = '0;
        end
      end
      if (e.closed_contact != closed_reg) begin
        send_next = 1'b1;
      end
      closed_next = e.closed_contact;
      need_pos    = (cur != MOVE_NONE) && (cfg.travel_time_ms != '0);
    end
  end

  assign dividend = DIVIDEND_W'(elapsed_next) * DIVIDEND_W'(FULL_PCT);

  dtpm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (cfg.travel_time_ms),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    pos_clamp  = (div_q > DIVIDEND_W'(FULL_PCT)) ? FULL_PCT : div_q[6:0];
    pos        = (move_reg == MOVE_DOWN) ? FULL_PCT - pos_clamp : pos_clamp;
    diff       = (pos >= reported_position) ? pos - reported_position
                                            : reported_position - pos;
    pos_report = (cfg.min_report_step != '0) && (diff >= cfg.min_report_step);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (head.valid) begin
          state_next = need_pos ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    div_start = 1'b0;
    pos_take  = 1'b0;
    emit      = 1'b0;
    case (state)
      ST_IDLE: begin
        pop       = head.valid;
        div_start = head.valid && need_pos;
      end
      ST_DIV:  pos_take = div_done;
      ST_EMIT: emit = !out_valid || out_ready;
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      move_reg          <= MOVE_NONE;
      elapsed_ms        <= '0;
      debounce_left     <= '0;
      pulse_left        <= '0;
      position_reg      <= '0;
      reported_position <= '0;
      closed_reg        <= 1'b0;
      enabled_reg       <= 1'b0;
      cmd_pend          <= 1'b0;
      send_pend         <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        move_reg      <= move_next;
        elapsed_ms    <= elapsed_next;
        debounce_left <= debounce_next;
        pulse_left    <= pulse_next;
        closed_reg    <= closed_next;
        enabled_reg   <= e.enable_level;
        cmd_pend      <= cmd_next;
        send_pend     <= send_next;
      end
      if (pos_take) begin
        position_reg <= pos;
        if (pos_report) begin
          reported_position <= pos;
          send_pend         <= 1'b1;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.command_level <= cmd_pend;
      out_data.report_due    <= send_pend;
      out_data.move_state    <= move_reg;
      out_data.position_pct  <= position_reg;
      out_data.closed_flag   <= closed_reg;
      out_data.enabled_flag  <= enabled_reg;
    end
  end

endmodule
